// ----- src/pse_pkg.sv -----
// Package for the postfix stack evaluator: token kind codes, result status codes,
// state machine types and the control/status structs for the serial arithmetic unit.
// No dependencies.
package pse_pkg;

    localparam int unsigned DATA_W = 32;

    // Token kinds as carried in the input tuser.
    localparam logic [2:0] KIND_NUM = 3'd0;
    localparam logic [2:0] KIND_ADD = 3'd1;
    localparam logic [2:0] KIND_SUB = 3'd2;
    localparam logic [2:0] KIND_MUL = 3'd3;
    localparam logic [2:0] KIND_DIV = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LEFTOVER = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_DIVZERO  = 2'd3;

    // Value reported with any error status.
    localparam logic [DATA_W-1:0] VALUE_ERR = '1;

    typedef enum logic [2:0] {
        T_IDLE,
        T_READ,
        T_LOAD,
        T_CALC,
        T_FINISH,
        T_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_FIX,
        A_DONE
    } alu_state_t;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } alu_ctrl_t;

    typedef struct packed {
        logic done;
        logic divzero;
    } alu_stat_t;

endpackage

// ----- src/pse_serial_alu.sv -----
// Serial arithmetic unit: add and subtract one bit per cycle, multiply and divide
// one operand bit per cycle over 32 steps. Depends on pse_pkg.
module pse_serial_alu
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pse_pkg::alu_ctrl_t            ctrl,
    input  logic [pse_pkg::DATA_W-1:0]    a,
    input  logic [pse_pkg::DATA_W-1:0]    b,
    output pse_pkg::alu_stat_t            stat,
    output logic [pse_pkg::DATA_W-1:0]    result
);

    localparam int unsigned W = pse_pkg::DATA_W;

    pse_pkg::alu_state_t state_reg, state_next;

    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] acc_reg, acc_next;
    logic         carry_reg, carry_next;
    logic         neg_reg, neg_next;
    logic         dz_reg, dz_next;
    logic [2:0]   op_reg, op_next;
    logic [4:0]   bit_cnt_reg, bit_cnt_next;

    logic         b_bit;
    logic         sum_bit;
    logic [W:0]   rem_sh;
    logic [W:0]   diff;
    logic         last_step;

    assign last_step = (bit_cnt_reg == 5'd31);
    assign b_bit     = (op_reg == pse_pkg::KIND_SUB) ? ~b_reg[0] : b_reg[0];
    assign sum_bit   = a_reg[0] ^ b_bit ^ carry_reg;
    assign rem_sh    = {acc_reg, a_reg[W-1]};
    assign diff      = rem_sh - {1'b0, b_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pse_pkg::A_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = pse_pkg::A_RUN;
                end
            end
            pse_pkg::A_RUN:
            begin
                if (last_step)
                begin
                    state_next = (op_reg == pse_pkg::KIND_DIV) ? pse_pkg::A_FIX
                                                               : pse_pkg::A_DONE;
                end
            end
            pse_pkg::A_FIX:  state_next = pse_pkg::A_DONE;
            pse_pkg::A_DONE: state_next = pse_pkg::A_IDLE;
            default:         state_next = pse_pkg::A_IDLE;
        endcase
    end

    // Datapath.
    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        acc_next     = acc_reg;
        carry_next   = carry_reg;
        neg_next     = neg_reg;
        dz_next      = dz_reg;
        op_next      = op_reg;
        bit_cnt_next = bit_cnt_reg;
        case (state_reg)
            pse_pkg::A_IDLE:
            begin
                if (ctrl.start)
                begin
                    op_next      = ctrl.op;
                    bit_cnt_next = '0;
                    acc_next     = '0;
                    carry_next   = (ctrl.op == pse_pkg::KIND_SUB);
                    if (ctrl.op == pse_pkg::KIND_DIV)
                    begin
                        // Divide on magnitudes, fix the sign at the end.
                        a_next   = a[W-1] ? (~a + W'(1)) : a;
                        b_next   = b[W-1] ? (~b + W'(1)) : b;
                        neg_next = a[W-1] ^ b[W-1];
                        dz_next  = (b == '0);
                    end
                    else
                    begin
                        a_next   = a;
                        b_next   = b;
                        neg_next = 1'b0;
                        dz_next  = 1'b0;
                    end
                end
            end
            pse_pkg::A_RUN:
            begin
                bit_cnt_next = bit_cnt_reg + 5'd1;
                case (op_reg)
                    pse_pkg::KIND_MUL:
                    begin
                        acc_next = acc_reg + (b_reg[0] ? a_reg : '0);
                        a_next   = {a_reg[W-2:0], 1'b0};
                        b_next   = {1'b0, b_reg[W-1:1]};
                    end
                    pse_pkg::KIND_DIV:
                    begin
                        // Restoring step: quotient bits shift into a_reg.
                        if (!diff[W])
                        begin
                            acc_next = diff[W-1:0];
                            a_next   = {a_reg[W-2:0], 1'b1};
                        end
                        else
                        begin
                            acc_next = rem_sh[W-1:0];
                            a_next   = {a_reg[W-2:0], 1'b0};
                        end
                    end
                    default:
                    begin
                        // Add or subtract, least significant bit first.
                        acc_next   = {sum_bit, acc_reg[W-1:1]};
                        carry_next = (a_reg[0] & b_bit) | (carry_reg & (a_reg[0] ^ b_bit));
                        a_next     = {1'b0, a_reg[W-1:1]};
                        b_next     = {1'b0, b_reg[W-1:1]};
                    end
                endcase
            end
            pse_pkg::A_FIX:
            begin
                if (dz_reg)
                begin
                    acc_next = '0;
                end
                else
                begin
                    acc_next = neg_reg ? (~a_reg + W'(1)) : a_reg;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pse_pkg::A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        acc_reg     <= acc_next;
        carry_reg   <= carry_next;
        neg_reg     <= neg_next;
        dz_reg      <= dz_next;
        op_reg      <= op_next;
        bit_cnt_reg <= bit_cnt_next;
    end

    assign stat.done    = (state_reg == pse_pkg::A_DONE);
    assign stat.divzero = dz_reg;
    assign result       = acc_reg;

endmodule

// ----- src/postfix_stack_evaluator_core.sv -----
// Top level of the postfix stack evaluator: token sequencer, operand stack memory
// and output register. Depends on pse_pkg and pse_serial_alu.
//
// The block takes one postfix token per input item and keeps an operand stack of
// STACK_DEPTH 32-bit entries in a local memory. The token kind travels in s_tuser
// and the number value in s_tdata. A number token is written to the stack in the
// cycle it is accepted; a push onto a full stack is dropped and remembered as an
// overflow. An operator token pops b and then a (an empty stack yields 0) and runs
// through a serial arithmetic unit that handles one bit per cycle. An operator item
// passes through the stack read, the operand load, the 32 steps of the serial unit,
// the sign fix of a divide, the done state and the write-back before the next item
// is accepted. A number or an unused token kind is taken without leaving the idle
// state. A token with tlast set then passes through a finish state that reads the
// bottom entry and an emit state that produces one result item, after which the
// stack and the error flags are cleared. A result holds the remaining value with
// status ok, or -1 with status divide by zero, overflow or leftover data, in that
// priority. A finished result waits in an output register, so further tokens are
// taken while it is pending; only a following last token waits for that register
// to empty.
module postfix_stack_evaluator_core
#(
    parameter int unsigned STACK_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic [2:0]  s_tuser,   // [2:0] kind
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] value, [33:32] status, [39:34] zero
);

    localparam int unsigned W  = pse_pkg::DATA_W;
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    pse_pkg::top_state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          dz_reg, dz_next;
    logic [2:0]    op_reg, op_next;
    logic          last_reg, last_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  out_value_reg, out_value_next;
    logic [1:0]    out_status_reg, out_status_next;

    // Stack memory and its registered read ports.
    logic [W-1:0]  stack_mem [STACK_DEPTH];
    logic [W-1:0]  rd_a_reg;
    logic [W-1:0]  rd_b_reg;

    logic [2:0]    in_kind;
    logic [W-1:0]  in_operand;
    logic          accept;
    logic          in_is_op;
    logic          cnt_ge1;
    logic          cnt_ge2;
    logic          cnt_full;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic          out_free;
    logic [1:0]    fin_status;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [W-1:0]  mem_wdata;
    logic          rd_en;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;

    pse_pkg::alu_ctrl_t alu_ctrl;
    pse_pkg::alu_stat_t alu_stat;
    logic [W-1:0]       alu_a;
    logic [W-1:0]       alu_b;
    logic [W-1:0]       alu_result;

    assign in_kind    = s_tuser;
    assign in_operand = s_tdata;
    assign accept     = s_tvalid && s_tready;
    assign in_is_op   = (in_kind >= pse_pkg::KIND_ADD) && (in_kind <= pse_pkg::KIND_DIV);

    assign cnt_ge1  = (count_reg != '0);
    assign cnt_ge2  = (count_reg >= CW'(2));
    assign cnt_full = (count_reg >= CW'(STACK_DEPTH));
    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign out_free = !out_valid_reg || m_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pse_pkg::T_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_is_op)
                    begin
                        state_next = pse_pkg::T_READ;
                    end
                    else if (s_tlast)
                    begin
                        state_next = pse_pkg::T_FINISH;
                    end
                end
            end
            pse_pkg::T_READ: state_next = pse_pkg::T_LOAD;
            pse_pkg::T_LOAD: state_next = pse_pkg::T_CALC;
            pse_pkg::T_CALC:
            begin
                if (alu_stat.done)
                begin
                    state_next = last_reg ? pse_pkg::T_FINISH : pse_pkg::T_IDLE;
                end
            end
            pse_pkg::T_FINISH: state_next = pse_pkg::T_EMIT;
            pse_pkg::T_EMIT:
            begin
                if (out_free)
                begin
                    state_next = pse_pkg::T_IDLE;
                end
            end
            default: state_next = pse_pkg::T_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, memory ports and serial unit control.
    always_comb
    begin
        s_tready       = (state_reg == pse_pkg::T_IDLE);
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = in_operand;
        rd_en          = 1'b0;
        rd_a_addr      = cnt_ge2 ? cnt_m2[AW-1:0] : '0;
        rd_b_addr      = cnt_ge1 ? cnt_m1[AW-1:0] : '0;
        alu_ctrl.start = 1'b0;
        alu_ctrl.op    = op_reg;
        case (state_reg)
            pse_pkg::T_IDLE:
            begin
                if (s_tvalid)
                begin
                    mem_we = (in_kind == pse_pkg::KIND_NUM) && !cnt_full;
                    rd_en  = in_is_op;
                end
            end
            pse_pkg::T_LOAD:
            begin
                alu_ctrl.start = 1'b1;
            end
            pse_pkg::T_CALC:
            begin
                mem_we    = alu_stat.done;
                mem_waddr = wr_addr_reg;
                mem_wdata = alu_result;
            end
            pse_pkg::T_FINISH:
            begin
                // With exactly one value left, it sits at the bottom entry.
                rd_en     = 1'b1;
                rd_b_addr = '0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Popped values from an empty stack read as zero.
    assign alu_a = cnt_ge2 ? rd_a_reg : '0;
    assign alu_b = cnt_ge1 ? rd_b_reg : '0;

    always_comb
    begin
        if (dz_reg)
        begin
            fin_status = pse_pkg::ST_DIVZERO;
        end
        else if (ovf_reg)
        begin
            fin_status = pse_pkg::ST_OVERFLOW;
        end
        else if (count_reg != CW'(1))
        begin
            fin_status = pse_pkg::ST_LEFTOVER;
        end
        else
        begin
            fin_status = pse_pkg::ST_OK;
        end
    end

    // Stack pointer, error flags and output register.
    always_comb
    begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        dz_next         = dz_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        wr_addr_next    = wr_addr_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        if (accept)
        begin
            op_next   = in_kind;
            last_next = s_tlast;
            if (in_kind == pse_pkg::KIND_NUM)
            begin
                if (cnt_full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
        end

        if (state_reg == pse_pkg::T_LOAD)
        begin
            // Two pops then one push: the result always fits.
            wr_addr_next = cnt_ge2 ? cnt_m2[AW-1:0] : '0;
            count_next   = (cnt_ge2 ? cnt_m2 : '0) + CW'(1);
        end

        if ((state_reg == pse_pkg::T_CALC) && alu_stat.done && alu_stat.divzero)
        begin
            dz_next = 1'b1;
        end

        if ((state_reg == pse_pkg::T_EMIT) && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = fin_status;
            out_value_next  = (fin_status == pse_pkg::ST_OK) ? rd_b_reg : pse_pkg::VALUE_ERR;
            count_next      = '0;
            ovf_next        = 1'b0;
            dz_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pse_pkg::T_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            dz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            dz_reg        <= dz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        last_reg       <= last_next;
        wr_addr_reg    <= wr_addr_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= stack_mem[rd_a_addr];
            rd_b_reg <= stack_mem[rd_b_addr];
        end
    end

    pse_serial_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .a      (alu_a),
        .b      (alu_b),
        .stat   (alu_stat),
        .result (alu_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_status_reg, out_value_reg};

`ifndef SYNTHESIS
    // The stack pointer never passes the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // The serial unit finishes only while the sequencer waits for it.
    a_alu_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        alu_stat.done |-> (state_reg == pse_pkg::T_CALC))
        else $error("serial unit finished outside the calculate state");

    // A new result is loaded only from the emit state.
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (!$past(out_valid_reg) || $past(m_tready)))
        |-> $past(state_reg == pse_pkg::T_EMIT))
        else $error("result loaded outside the emit state");

    // Every error status carries the error value.
    a_error_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != pse_pkg::ST_OK))
        |-> (out_value_reg == pse_pkg::VALUE_ERR))
        else $error("error status without error value");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for postfix_stack_evaluator_core: streams postfix tokens,
// predicts each expression's result and checks it. Depends on pse_pkg and the core.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned DEPTH        = 16;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          REPORT_MAX   = 10;

    // Token kinds that the block ignores.
    localparam logic [2:0] KIND_RSVD5 = 3'd5;
    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;

    localparam logic [31:0] INT_MAX   = 32'h7fff_ffff;
    localparam logic [31:0] INT_MIN   = 32'h8000_0000;
    localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
    } rpn_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // Predictor state.
    logic [31:0] rpn_stack [DEPTH];
    int unsigned rpn_depth = 0;
    bit          rpn_overflow = 1'b0;
    bit          rpn_divzero = 1'b0;
    rpn_result_t pending_results[$];

    int  tokens_sent = 0;
    int  results_seen = 0;
    int  error_count = 0;
    int  stall_cycles = 0;
    int  cycle_count = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    int  sink_hold_cycles = 0;
    int  rx_stall_left = 0;

    postfix_stack_evaluator_core #(
        .STACK_DEPTH(DEPTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'd1;
            2: return MINUS_ONE;
            3: return INT_MIN;
            4: return INT_MAX;
            5, 6: return ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 20))
                                                     : -32'($urandom_range(0, 20));
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_operand(input logic [31:0] v);
        if (rpn_depth < DEPTH)
        begin
            rpn_stack[rpn_depth] = v;
            rpn_depth++;
        end
        else
            rpn_overflow = 1'b1;
    endfunction

    // An empty stack yields zero.
    function automatic logic [31:0] pop_operand();
        if (rpn_depth == 0)
            return '0;
        rpn_depth--;
        return rpn_stack[rpn_depth];
    endfunction

    function automatic logic [31:0] divide_trunc(input logic [31:0] a, input logic [31:0] b);
        longint sa;
        longint sb;
        longint q;
        if (b == '0)
        begin
            rpn_divzero = 1'b1;
            return '0;
        end
        sa = $signed(a);
        sb = $signed(b);
        q  = sa / sb;
        return q[31:0];
    endfunction

    function automatic void apply_token(input logic [2:0] kind, input logic [31:0] operand,
                                        input logic is_last);
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] res;
        rpn_result_t r;
        if (kind == pse_pkg::KIND_NUM)
            push_operand(operand);
        else if (kind <= pse_pkg::KIND_DIV)
        begin
            rhs = pop_operand();
            lhs = pop_operand();
            case (kind)
                pse_pkg::KIND_ADD: res = lhs + rhs;
                pse_pkg::KIND_SUB: res = lhs - rhs;
                pse_pkg::KIND_MUL: res = lhs * rhs;
                default:           res = divide_trunc(lhs, rhs);
            endcase
            push_operand(res);
        end
        if (is_last)
        begin
            if (rpn_divzero)
                r.status = pse_pkg::ST_DIVZERO;
            else if (rpn_overflow)
                r.status = pse_pkg::ST_OVERFLOW;
            else if (rpn_depth != 1)
                r.status = pse_pkg::ST_LEFTOVER;
            else
                r.status = pse_pkg::ST_OK;
            r.value = (r.status == pse_pkg::ST_OK) ? rpn_stack[0] : pse_pkg::VALUE_ERR;
            pending_results.push_back(r);
            rpn_depth    = 0;
            rpn_overflow = 1'b0;
            rpn_divzero  = 1'b0;
        end
    endfunction

    // Offers one token and returns right after the edge that accepts it; valid stays
    // high so that a following token without a gap goes out back to back.
    task automatic send_token(input logic [2:0] kind, input logic [31:0] operand,
                              input logic is_last);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= operand;
        s_tuser  <= kind;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
        begin
            stall_cycles++;
            @(posedge clk);
        end
        apply_token(kind, operand, is_last);
        if (kind <= pse_pkg::KIND_DIV)
            tokens_sent++;
    endtask

    // Sends a well-formed expression over n_nums numbers; push_pct biases toward
    // pushing before reducing, so a high value builds a deep stack.
    task automatic send_expression(input int n_nums, input int push_pct);
        int          nums_left;
        int          level;
        logic [2:0]  op;
        nums_left = n_nums;
        level     = 0;
        while (nums_left > 0 || level > 1)
        begin
            if (nums_left > 0 && (level < 2 || $urandom_range(0, 99) < push_pct))
            begin
                nums_left--;
                level++;
                send_token(pse_pkg::KIND_NUM, pick_operand(), nums_left == 0 && level == 1);
            end
            else
            begin
                op = 3'($urandom_range(pse_pkg::KIND_ADD, pse_pkg::KIND_DIV));
                level--;
                send_token(op, $urandom, nums_left == 0 && level == 1);
            end
        end
    endtask

    // Wrap-around, truncating division, the most negative value over -1, divide by
    // zero, pops from an empty stack, ignored kinds, leftover and empty stacks.
    task automatic test_directed_tokens();
        send_token(pse_pkg::KIND_NUM, INT_MAX, 1'b0);
        send_token(pse_pkg::KIND_NUM, 32'd1, 1'b0);
        send_token(pse_pkg::KIND_ADD, $urandom, 1'b0);
        send_token(pse_pkg::KIND_NUM, MINUS_ONE, 1'b0);
        send_token(pse_pkg::KIND_DIV, $urandom, 1'b0);
        send_token(pse_pkg::KIND_NUM, 32'd3, 1'b0);
        send_token(pse_pkg::KIND_MUL, $urandom, 1'b1);

        send_token(pse_pkg::KIND_NUM, -32'd7, 1'b0);
        send_token(pse_pkg::KIND_NUM, 32'd2, 1'b0);
        send_token(KIND_RSVD6, $urandom, 1'b0);
        send_token(pse_pkg::KIND_DIV, $urandom, 1'b0);
        send_token(pse_pkg::KIND_NUM, 32'd0, 1'b0);
        send_token(pse_pkg::KIND_SUB, $urandom, 1'b1);

        send_token(pse_pkg::KIND_NUM, 32'd5, 1'b0);
        send_token(pse_pkg::KIND_NUM, 32'd0, 1'b0);
        send_token(pse_pkg::KIND_DIV, $urandom, 1'b1);

        send_token(pse_pkg::KIND_SUB, $urandom, 1'b1);

        send_token(pse_pkg::KIND_NUM, 32'd1, 1'b0);
        send_token(pse_pkg::KIND_NUM, 32'd2, 1'b0);
        send_token(KIND_RSVD7, $urandom, 1'b1);

        send_token(KIND_RSVD5, $urandom, 1'b1);
    endtask

    task automatic test_random_expressions();
        int target;
        int n;
        target = tokens_sent + 330;
        n = 0;
        while (tokens_sent < target)
        begin
            // Switch idling on and off in stretches.
            if (n % 8 == 0)
            begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_expression($urandom_range(1, 8), $urandom_range(20, 80));
            n++;
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Deep stacks: some reach the full depth exactly, others push past it.
    task automatic test_deep_stack();
        int target;
        target = tokens_sent + 90;
        send_expression(DEPTH, 100);
        while (tokens_sent < target)
            send_expression($urandom_range(DEPTH - 2, DEPTH + 4), $urandom_range(85, 100));
    endtask

    task automatic test_malformed_streams();
        int         target;
        logic [2:0] kind;
        target = tokens_sent + 80;
        while (tokens_sent < target)
        begin
            if ($urandom_range(0, 1) != 0)
                kind = pse_pkg::KIND_NUM;
            else
                kind = 3'($urandom_range(0, 7));
            send_token(kind, pick_operand(), $urandom_range(0, 99) < 20);
        end
        // Close whatever is left open.
        send_token(KIND_RSVD7, $urandom, 1'b1);
    endtask

    // The sink holds off while short expressions keep coming, so the output
    // register fills and the next last token has to wait.
    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        sink_hold_cycles = 1200;
        repeat (14)
            send_expression($urandom_range(1, 3), 50);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                sink_hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_idle_en)
                    rx_stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        rpn_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("Result %0d arrived with nothing expected: %s %0d status %0d",
                             results_seen, "value", $signed(m_tdata[31:0]),
                             m_tdata[33:32]);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.value || m_tdata[33:32] !== want.status)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("Result %0d: expected value %0d status %0d, %s %0d %s %0d",
                                 results_seen, $signed(want.value), want.status,
                                 "got value", $signed(m_tdata[31:0]),
                                 "status", m_tdata[33:32]);
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_tokens();
        test_random_expressions();
        test_deep_stack();
        test_malformed_streams();
        test_output_backpressure();
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d operand and operator tokens, checked %0d expression results.",
                 tokens_sent, results_seen);
        $display("Input was held back for %0d cycles; %0d results were wrong or unexpected.",
                 stall_cycles, error_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
